// File: rtl/status_led_pattern_blinker_macros.svh
// Assertion shorthands used by the checker of the status LED blinker.
`ifndef STATUS_LED_PATTERN_BLINKER_MACROS_SVH
`define STATUS_LED_PATTERN_BLINKER_MACROS_SVH

// same-cycle implication under reset
`define SLPB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("status LED blinker check failed");

// next-cycle implication under reset
`define SLPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("status LED blinker check failed");

`endif

// File: rtl/slpb_pkg.sv
`default_nettype none

package slpb_pkg;

	localparam logic [31:0] CHECK_PERIOD_MS = 32'd100;
	localparam logic [5:0]  ERROR_HOLD      = 6'd50;

	localparam logic [15:0] OK_ON_RST      = 16'd1500;
	localparam logic [15:0] OK_OFF_RST     = 16'd1500;
	localparam logic [15:0] NOSIG_ON_RST   = 16'd50;
	localparam logic [15:0] NOSIG_OFF_RST  = 16'd450;
	localparam logic [15:0] OVF_SHORT_RST  = 16'd100;
	localparam logic [15:0] OVF_LONG_RST   = 16'd400;
	localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

	localparam logic [2:0] FIRST_STEP         = 3'd1;
	localparam logic [2:0] OVF_LAST_STEP      = 3'd6;
	localparam logic [2:0] TWO_PHASE_LAST_STEP = 3'd2;

	typedef enum logic [1:0] {
		PAT_OK    = 2'd0,
		PAT_NOSIG = 2'd1,
		PAT_OVF   = 2'd2
	} pattern_t;

	typedef enum logic [2:0] {
		REG_LED_ENABLE = 3'd0,
		REG_OK_ON      = 3'd1,
		REG_OK_OFF     = 3'd2,
		REG_NOSIG_ON   = 3'd3,
		REG_NOSIG_OFF  = 3'd4,
		REG_OVF_SHORT  = 3'd5,
		REG_OVF_LONG   = 3'd6,
		REG_TIMEOUT    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic        tick;
		logic        signal_report;
		logic [15:0] signal_age;
		logic        send_overflow;
	} item_t;

	typedef struct packed {
		logic       led_level;
		logic [1:0] pattern;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/status_led_pattern_blinker.sv
// Status LED blinker: each accepted transaction (millisecond tick, signal report with its
// age, send-overflow flag) yields exactly one result with the LED level and the active
// pattern. A transaction is taken every cycle while item_stall is low; the whole step is
// one pass of compare/add logic between the state registers and the result register,
// and a one-deep skid stage lets the next transaction in while a result still waits.
// item_stall rises only when both the result register and the skid stage are full.
// While enabled, every CHECK_PERIOD_MS ticks the signal timeout is checked, the overflow
// hold counts down and the pattern is picked; a pattern change restarts the blink sequence
// at once. Configuration writes take effect at the next edge and belong to idle periods.
`default_nettype none

module status_led_pattern_blinker
	import slpb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result,
	input  wire logic    cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic        led_en_q;
	logic [15:0] ok_on_q, ok_off_q, nosig_on_q, nosig_off_q;
	logic [15:0] ovf_short_q, ovf_long_q, timeout_q;

	logic [31:0] now_q, last_sig_q, next_check_q, next_flash_q;
	logic        sig_valid_q;
	logic [5:0]  hold_q;
	logic [2:0]  step_q;
	pattern_t    pat_q;
	logic        led_q;

	logic        out_valid_q, skid_valid_q;
	result_t     out_q, skid_q;

	logic        item_fire, result_fire;

	logic [31:0] now_d, last_sig_d, next_check_d, next_flash_d;
	logic        sig_valid_d;
	logic [5:0]  hold_d;
	logic [2:0]  step_d;
	pattern_t    pat_d;
	logic        led_d;
	result_t     res_d;

	logic        report_ok, lost, check_go, changed, flash_go;
	logic [31:0] age_diff;
	logic        valid_a;
	logic [5:0]  hold_a;
	pattern_t    pick;
	logic [2:0]  step_b, step_fix, last_step;
	logic [31:0] flash_b;
	logic [15:0] phase;

	// true while the event time still lies ahead of now (wrap-safe)
	function automatic logic next_check_sub(input logic [31:0] now, input logic [31:0] due);
		logic [31:0] d;
		d = now - due;
		return d[31];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_en_q    <= 1'b0;
			ok_on_q     <= OK_ON_RST;
			ok_off_q    <= OK_OFF_RST;
			nosig_on_q  <= NOSIG_ON_RST;
			nosig_off_q <= NOSIG_OFF_RST;
			ovf_short_q <= OVF_SHORT_RST;
			ovf_long_q  <= OVF_LONG_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LED_ENABLE: led_en_q    <= cfg_data[0];
				REG_OK_ON:      ok_on_q     <= cfg_data;
				REG_OK_OFF:     ok_off_q    <= cfg_data;
				REG_NOSIG_ON:   nosig_on_q  <= cfg_data;
				REG_NOSIG_OFF:  nosig_off_q <= cfg_data;
				REG_OVF_SHORT:  ovf_short_q <= cfg_data;
				REG_OVF_LONG:   ovf_long_q  <= cfg_data;
				REG_TIMEOUT:    timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		now_d        = now_q;
		last_sig_d   = last_sig_q;
		sig_valid_d  = sig_valid_q;
		next_check_d = next_check_q;
		next_flash_d = next_flash_q;
		step_d       = step_q;
		pat_d        = pat_q;
		led_d        = led_q;

		hold_a    = item.send_overflow ? ERROR_HOLD : hold_q;
		valid_a   = sig_valid_q;
		report_ok = ({16'd0, item.signal_age} <= {16'd0, timeout_q});
		if (item.signal_report) begin
			if (report_ok) begin
				last_sig_d = now_q - {16'd0, item.signal_age};
				valid_a    = 1'b1;
			end else begin
				valid_a = 1'b0;
				hold_a  = '0;
			end
		end
		age_diff = (item.signal_report && report_ok) ?
			{16'd0, item.signal_age} : (now_q - last_sig_q);

		check_go = item.tick && led_en_q && !next_check_sub(now_q, next_check_q);
		lost     = valid_a && (age_diff > {16'd0, timeout_q});
		sig_valid_d = valid_a;
		hold_d      = hold_a;
		pick        = PAT_OK;
		changed     = 1'b0;
		step_b      = step_q;
		flash_b     = next_flash_q;
		if (check_go) begin
			next_check_d = now_q + CHECK_PERIOD_MS;
			if (lost) begin
				sig_valid_d = 1'b0;
				hold_d      = '0;
			end
			priority if (!sig_valid_d) begin
				pick = PAT_NOSIG;
			end else if (hold_d != '0) begin
				pick   = PAT_OVF;
				hold_d = hold_d - 6'd1;
			end else begin
				pick = PAT_OK;
			end
			changed = (pick != pat_q);
			if (changed) begin
				pat_d   = pick;
				flash_b = now_q;
				step_b  = FIRST_STEP;
			end
		end
		next_flash_d = flash_b;
		step_d       = step_b;

		flash_go  = item.tick && led_en_q && (changed || !next_check_sub(now_q, next_flash_q));
		last_step = (pat_d == PAT_OVF) ? OVF_LAST_STEP : TWO_PHASE_LAST_STEP;
		step_fix  = (step_b > last_step || step_b == '0) ? FIRST_STEP : step_b;
		unique case (pat_d)
			PAT_OVF:   phase = (step_fix == OVF_LAST_STEP) ? ovf_long_q : ovf_short_q;
			PAT_NOSIG: phase = step_fix[0] ? nosig_on_q : nosig_off_q;
			PAT_OK:    phase = step_fix[0] ? ok_on_q : ok_off_q;
			default:   phase = step_fix[0] ? ok_on_q : ok_off_q;
		endcase
		if (flash_go) begin
			next_flash_d = now_q + {16'd0, phase};
			led_d        = step_fix[0];
			step_d       = step_fix + 3'd1;
		end

		if (item.tick) begin
			now_d = now_q + 32'd1;
		end

		res_d.led_level = led_en_q & led_d;
		res_d.pattern   = pat_d;
	end

	assign item_fire   = item_valid && !skid_valid_q;
	assign result_fire = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			last_sig_q   <= '0;
			sig_valid_q  <= 1'b0;
			hold_q       <= '0;
			next_check_q <= '0;
			next_flash_q <= '0;
			step_q       <= FIRST_STEP;
			pat_q        <= PAT_OK;
			led_q        <= 1'b0;
		end else if (item_fire) begin
			now_q        <= now_d;
			last_sig_q   <= last_sig_d;
			sig_valid_q  <= sig_valid_d;
			hold_q       <= hold_d;
			next_check_q <= next_check_d;
			next_flash_q <= next_flash_d;
			step_q       <= step_d;
			pat_q        <= pat_d;
			led_q        <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (result_fire || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= item_fire;
				end
			end else if (item_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_fire || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end else if (item_fire) begin
			skid_q <= res_d;
		end
	end

	assign item_stall   = skid_valid_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// File: rtl/slpb_checker.sv
`default_nettype none
`include "status_led_pattern_blinker_macros.svh"

module slpb_checker
	import slpb_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// hold a stalled result
	`SLPB_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))
	// every accepted transaction shows a result next cycle
	`SLPB_ASSERT_NEXT(a_item_gives_result, clk, arst_n, item_valid && !item_stall, result_valid)
	// stall only with a full result register
	`SLPB_ASSERT_NOW(a_stall_needs_result, clk, arst_n, item_stall, result_valid)
	// drain the skid stage as soon as the result is taken
	`SLPB_ASSERT_NEXT(a_skid_drains, clk, arst_n, item_stall && !result_stall, !item_stall)

endmodule

bind status_led_pattern_blinker slpb_checker u_slpb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
